// File: hw/rtl/sgnms_pkg.sv
package sgnms_pkg;

  // Fixed field widths of the streaming interface
  localparam int COL_W   = 10;
  localparam int ROW_W   = 12;
  localparam int MAG_W   = 11;
  localparam int DIR_W   = 2;
  localparam int PIX_W   = 8;
  localparam int GRAD_W  = MAG_W + DIR_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_WIDTH_BITS  = 11;
  localparam int CFG_HEIGHT_BITS = 13;

  // Register reset values
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // Direction sectors
  localparam logic [DIR_W-1:0] SEC_HORZ = 2'd0;
  localparam logic [DIR_W-1:0] SEC_NESW = 2'd1;
  localparam logic [DIR_W-1:0] SEC_VERT = 2'd2;
  localparam logic [DIR_W-1:0] SEC_NWSE = 2'd3;

  // Fixed tangent of 22.5 degrees as TAN_NUM / 2^TAN_SHIFT
  localparam int TAN_NUM   = 3393;
  localparam int TAN_SHIFT = 13;

  // Square root unit: radicand below 2^(2*SQRT_STEPS)
  localparam int SQRT_STEPS = 11;
  localparam int SQRT_IN_W  = 2 * SQRT_STEPS;
  localparam int SQRT_CNT_W = 4;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [MAG_W-1:0] magnitude;
    logic [DIR_W-1:0] direction;
    logic             is_peak;
    logic             frame_end;
  } out_item_t;

endpackage

// File: hw/rtl/sobel_gradient_nonmax_suppress_top.sv
// Sequence: a transaction that computes an interior gradient steps through memory read,
// window update, Sobel, squares, square root, gradient window update and NMS emit;
// any other transaction goes from the window update straight to the gradient step and
// then to the emit step. The next transaction is taken only once the emit step is left. One transaction is in
// flight at a time, a stalled result holds the emit step, and a result appears 2W+2
// transactions after its pixel. rst (synchronous) clears the window, positions and sizes
// (640x480); the line memories are not cleared.
module sobel_gradient_nonmax_suppress_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  sgnms_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output sgnms_pkg::out_item_t                out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sgnms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgnms_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import sgnms_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = XW + 1;
  localparam int HW = $clog2(MAX_HEIGHT) + 1;
  localparam int YW = HW + 1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_SOBEL = 7'b0000100,
    ST_SQ    = 7'b0001000,
    ST_ROOT  = 7'b0010000,
    ST_GRAD  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t state;

  // Frame size, clamped at write
  logic [WW-1:0] wc;
  logic [HW-1:0] hc;
  int            w_int;
  int            h_int;

  always_comb begin
    w_int = int'(cfg_data[CFG_WIDTH_BITS-1:0]);
    h_int = int'(cfg_data[CFG_HEIGHT_BITS-1:0]);
    if (w_int < 3) w_int = 3;
    if (w_int > MAX_WIDTH) w_int = MAX_WIDTH;
    if (h_int < 3) h_int = 3;
    if (h_int > MAX_HEIGHT) h_int = MAX_HEIGHT;
  end

  // Take register writes only while no transaction is in flight
  assign cfg_ready = (state == ST_IDLE);

  // Stream position of the current step
  logic [XW-1:0] sx;
  logic [YW-1:0] sy;
  logic [YW-1:0] hx;
  logic [XW-1:0] w_last;

  assign hx     = YW'(hc);
  assign w_last = XW'(wc - 1'b1);

  logic pix_go, drain_go, go;
  assign pix_go   = !in_data.action && (sy < hx);
  assign drain_go = (sy >= hx);
  assign go       = in_valid && !in_stall && (pix_go || drain_go);

  // Gradient position (lags by W+1)
  logic [XW-1:0] qx_c;
  logic [YW-1:0] qy_c;
  logic          q_ok_c, q_int_c;

  always_comb begin
    if (sx != '0) begin
      qx_c = sx - 1'b1;
      qy_c = sy - 1'b1;
    end else begin
      qx_c = w_last;
      qy_c = sy - YW'(2);
    end
    q_ok_c  = ((sy >= YW'(2)) || (sy == YW'(1) && sx != '0)) && (qy_c < hx);
    q_int_c = (qx_c != '0) && (WW'(qx_c) + 1'b1 < wc) &&
              (qy_c != '0) && (qy_c + 1'b1 < hx);
  end

  // Output position (lags by 2W+2)
  logic [XW-1:0] px_c;
  logic [YW-1:0] py_c;
  logic          p_ok_c, p_int_c, fend_c;

  always_comb begin
    if (sx >= XW'(2)) begin
      px_c = sx - XW'(2);
      py_c = sy - YW'(2);
    end else begin
      px_c = XW'(WW'(sx) + wc - WW'(2));
      py_c = sy - YW'(3);
    end
    p_ok_c  = (sy >= YW'(3)) || (sy == YW'(2) && sx >= XW'(2));
    p_int_c = (px_c != '0) && (WW'(px_c) + 1'b1 < wc) &&
              (py_c != '0) && (py_c + 1'b1 < hx);
    fend_c  = p_ok_c && (px_c == w_last) && (py_c == hx - 1'b1);
  end

  // Per-transaction context
  logic             has_pix, q_ok, q_int, p_ok, p_int, fend;
  logic [XW-1:0]    sx_r, qx_r, px_r;
  logic [YW-1:0]    py_r;
  logic [PIX_W-1:0] pix_r;

  // Line memories: two lines per entry, {older, newer}
  logic [2*PIX_W-1:0]  pmem [MAX_WIDTH];
  logic [2*GRAD_W-1:0] gmem [MAX_WIDTH];
  logic [2*PIX_W-1:0]  prd;
  logic [2*GRAD_W-1:0] grd;
  logic [GRAD_W-1:0]   g_new;

  always_ff @(posedge clk) begin
    if (go) begin
      prd <= pmem[sx];
      grd <= gmem[qx_c];
    end
    if (state == ST_READ && has_pix) begin
      pmem[sx_r] <= {prd[PIX_W-1:0], pix_r};
    end
    if (state == ST_GRAD && q_ok) begin
      gmem[qx_r] <= {grd[GRAD_W-1:0], g_new};
    end
  end

  // Windows: [row][col], row 0 top, col 2 newest
  logic [PIX_W-1:0]  pw [3][3];
  logic [GRAD_W-1:0] gw [3][3];

  // Sobel and sector
  logic [PIX_W+1:0]  sum_r, sum_l, sum_t, sum_b;
  logic signed [MAG_W-1:0] hh_c, vv_c, hh, vv;
  logic signed [SQRT_IN_W-1:0] hx2, vx2;
  logic [SQRT_IN_W-1:0] sumsq;
  logic [PIX_W+1:0]  ah, av;
  logic              hpos;
  logic [SQRT_IN_W:0] lhs0, rhs0, lhs1, rhs1;
  logic [DIR_W-1:0]  sec_c, sec;
  logic              sqrt_done;
  logic [MAG_W-1:0]  sqrt_root;

  always_comb begin
    sum_r = (PIX_W+2)'(pw[0][2]) + (PIX_W+2)'({pw[1][2], 1'b0}) + (PIX_W+2)'(pw[2][2]);
    sum_l = (PIX_W+2)'(pw[0][0]) + (PIX_W+2)'({pw[1][0], 1'b0}) + (PIX_W+2)'(pw[2][0]);
    sum_t = (PIX_W+2)'(pw[0][0]) + (PIX_W+2)'({pw[0][1], 1'b0}) + (PIX_W+2)'(pw[0][2]);
    sum_b = (PIX_W+2)'(pw[2][0]) + (PIX_W+2)'({pw[2][1], 1'b0}) + (PIX_W+2)'(pw[2][2]);
    hh_c  = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
    vv_c  = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
  end

  always_comb begin
    hx2   = SQRT_IN_W'(hh);
    vx2   = SQRT_IN_W'(vv);
    sumsq = SQRT_IN_W'(hx2 * hx2) + SQRT_IN_W'(vx2 * vx2);
    ah    = (PIX_W+2)'(hh < 0 ? -hh : hh);
    av    = (PIX_W+2)'(vv < 0 ? -vv : vv);
    hpos  = (vv < 0) ? (hh < 0) : (hh > 0);
    lhs0  = (SQRT_IN_W+1)'(av) << TAN_SHIFT;
    rhs0  = (SQRT_IN_W+1)'(ah) * (SQRT_IN_W+1)'(TAN_NUM);
    lhs1  = (SQRT_IN_W+1)'(av) * (SQRT_IN_W+1)'(TAN_NUM);
    rhs1  = (SQRT_IN_W+1)'(ah) << TAN_SHIFT;
    priority if (lhs0 <= rhs0) sec_c = SEC_HORZ;
    else if (lhs1 <= rhs1)     sec_c = hpos ? SEC_NESW : SEC_NWSE;
    else                       sec_c = SEC_VERT;
  end

  sgnms_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_SQ),
    .num   (sumsq),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign g_new = (has_pix && q_int) ? {sec, sqrt_root} : '0;

  // Non-maximum suppression on the gradient window
  logic [GRAD_W-1:0] ctr, n1, n2;
  logic [MAG_W-1:0]  cmag;
  logic              keep;
  out_item_t         res;

  always_comb begin
    ctr  = gw[1][1];
    cmag = ctr[MAG_W-1:0];
    unique case (ctr[GRAD_W-1:MAG_W])
      SEC_HORZ: begin n1 = gw[1][0]; n2 = gw[1][2]; end
      SEC_NESW: begin n1 = gw[0][2]; n2 = gw[2][0]; end
      SEC_VERT: begin n1 = gw[0][1]; n2 = gw[2][1]; end
      default:  begin n1 = gw[0][0]; n2 = gw[2][2]; end
    endcase
    keep = (cmag > n1[MAG_W-1:0]) && (cmag > n2[MAG_W-1:0]);
    res.col       = COL_W'(px_r);
    res.row       = ROW_W'(py_r);
    res.magnitude = (p_int && keep) ? cmag : '0;
    res.direction = p_int ? ctr[GRAD_W-1:MAG_W] : SEC_HORZ;
    res.is_peak   = p_int && keep;
    res.frame_end = fend;
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || cfg_valid;

  // Raise valid on a loaded result, drop it once the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && p_ok && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer, windows and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wc        <= WW'(WIDTH_RESET > MAX_WIDTH ? MAX_WIDTH : WIDTH_RESET);
      hc        <= HW'(HEIGHT_RESET > MAX_HEIGHT ? MAX_HEIGHT : HEIGHT_RESET);
      sx        <= '0;
      sy        <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pw[r][c] <= '0;
          gw[r][c] <= '0;
        end
      end
    end else begin
      // Take register writes and restart the frame
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WIDTH:  wc <= WW'(w_int);
          REG_HEIGHT: hc <= HW'(h_int);
          default:    ;
        endcase
        sx <= '0;
        sy <= '0;
      end

      unique case (state)
        ST_IDLE: begin
          if (go) begin
            has_pix <= pix_go;
            q_ok    <= q_ok_c;
            q_int   <= q_int_c;
            p_ok    <= p_ok_c;
            p_int   <= p_int_c;
            fend    <= fend_c;
            sx_r    <= sx;
            qx_r    <= qx_c;
            px_r    <= px_c;
            py_r    <= py_c;
            pix_r   <= in_data.pixel;
            if (fend_c) begin
              sx <= '0;
              sy <= '0;
            end else if (sx == w_last) begin
              sx <= '0;
              sy <= sy + 1'b1;
            end else begin
              sx <= sx + 1'b1;
            end
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (has_pix) begin
            for (int r = 0; r < 3; r++) begin
              pw[r][0] <= pw[r][1];
              pw[r][1] <= pw[r][2];
            end
            pw[0][2] <= prd[2*PIX_W-1:PIX_W];
            pw[1][2] <= prd[PIX_W-1:0];
            pw[2][2] <= pix_r;
          end
          state <= (has_pix && q_int) ? ST_SOBEL : ST_GRAD;
        end
        ST_SOBEL: begin
          hh    <= hh_c;
          vv    <= vv_c;
          state <= ST_SQ;
        end
        ST_SQ: begin
          sec   <= sec_c;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (sqrt_done) state <= ST_GRAD;
        end
        ST_GRAD: begin
          if (q_ok) begin
            for (int r = 0; r < 3; r++) begin
              gw[r][0] <= gw[r][1];
              gw[r][1] <= gw[r][2];
            end
            gw[0][2] <= grd[2*GRAD_W-1:GRAD_W];
            gw[1][2] <= grd[GRAD_W-1:0];
            gw[2][2] <= g_new;
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!p_ok) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_data  <= res;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
      (in_valid && !in_stall) |-> state == ST_IDLE)
    else $error("transaction accepted outside idle");
  a_load_emit: assert property (@(posedge clk) disable iff (rst)
      $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("result loaded outside emit step");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
      WW'(sx) < wc)
    else $error("column counter beyond frame width");
  a_fend_wrap: assert property (@(posedge clk) disable iff (rst)
      (state == ST_IDLE && go && fend_c && !cfg_valid) |=> (sx == '0 && sy == '0))
    else $error("position not cleared at frame end");

endmodule

// File: hw/rtl/sgnms_isqrt.sv
module sgnms_isqrt (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [sgnms_pkg::SQRT_IN_W-1:0]    num,
  output logic                               done,
  output logic [sgnms_pkg::MAG_W-1:0]        root
);
  import sgnms_pkg::*;

  logic                  busy;
  logic [SQRT_CNT_W-1:0] k;
  logic [SQRT_IN_W-1:0]  rem;
  logic [SQRT_IN_W-1:0]  acc;
  logic [SQRT_IN_W-1:0]  bit_c;
  logic [SQRT_IN_W-1:0]  trial;

  assign bit_c = SQRT_IN_W'(1) << (2 * k);
  assign trial = acc + bit_c;
  assign root  = acc[MAG_W-1:0];

  // Resolve one result bit per cycle, top bit first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= SQRT_CNT_W'(SQRT_STEPS - 1);
        rem  <= num;
        acc  <= '0;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          acc <= (acc >> 1) + bit_c;
        end else begin
          acc <= acc >> 1;
        end
        if (k == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k - 1'b1;
        end
      end
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("square root done held longer than one cycle");
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("square root restarted while busy");
  a_root_range: assert property (@(posedge clk) disable iff (rst)
      done |-> acc < SQRT_IN_W'(1) << SQRT_STEPS)
    else $error("square root result out of range");

endmodule

// File: tb/sv/sobel_gradient_nonmax_suppress_top_tb.sv
`timescale 1ns / 100ps

module sobel_gradient_nonmax_suppress_top_tb;
  import sgnms_pkg::*;

  localparam int LINE = 1024;
  localparam int HI_W = 1024;
  localparam int HI_H = 4096;
  localparam int SETTLE = 40;
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef enum int {ROW_MODEL, ROW_QUIET, ROW_TYPED, ROW_SET_W, ROW_SET_H} row_kind_t;

  typedef struct {
    row_kind_t kind;
    in_item_t  item;
    int        value;
    out_item_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sobel_gradient_nonmax_suppress_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Predictor state
  int unsigned reg_width = WIDTH_RESET;
  int unsigned reg_height = HEIGHT_RESET;
  logic [7:0] pix_rows [2*LINE];
  logic [12:0] grad_rows [2*LINE];
  logic [7:0] pix_win [3][3];
  logic [12:0] grad_win [3][3];
  int unsigned in_count = 0;
  int unsigned out_count = 0;

  out_item_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  bit steady_send = 0;
  bit steady_recv = 0;

  initial begin
    foreach (pix_rows[i]) pix_rows[i] = '0;
    foreach (grad_rows[i]) grad_rows[i] = '0;
    foreach (pix_win[r, c]) pix_win[r][c] = '0;
    foreach (grad_win[r, c]) grad_win[r][c] = '0;
  end

  function automatic int unsigned used_width();
    return (reg_width < 3) ? 3 : (reg_width > HI_W) ? HI_W : reg_width;
  endfunction

  function automatic int unsigned used_height();
    return (reg_height < 3) ? 3 : (reg_height > HI_H) ? HI_H : reg_height;
  endfunction

  function automatic bit is_interior(int unsigned x, int unsigned y, int unsigned w,
                                     int unsigned h);
    return x >= 1 && x + 2 <= w && y >= 1 && y + 2 <= h;
  endfunction

  function automatic int unsigned int_sqrt(int unsigned n);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int i = 11; i >= 0; i--) begin
      t = r | (32'd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // Sobel gradient of the window center, packed as sector over magnitude
  function automatic logic [12:0] center_gradient();
    int hh, vv;
    int unsigned ah, av, mag;
    logic [1:0] sec;
    hh = (int'(pix_win[0][2]) + 2 * int'(pix_win[1][2]) + int'(pix_win[2][2]))
       - (int'(pix_win[0][0]) + 2 * int'(pix_win[1][0]) + int'(pix_win[2][0]));
    vv = (int'(pix_win[0][0]) + 2 * int'(pix_win[0][1]) + int'(pix_win[0][2]))
       - (int'(pix_win[2][0]) + 2 * int'(pix_win[2][1]) + int'(pix_win[2][2]));
    mag = int_sqrt(hh * hh + vv * vv);
    if (vv < 0) begin
      vv = -vv;
      hh = -hh;
    end
    ah = (hh < 0) ? -hh : hh;
    av = vv;
    if (av * (1 << TAN_SHIFT) <= TAN_NUM * ah) sec = SEC_HORZ;
    else if (av * TAN_NUM <= (1 << TAN_SHIFT) * ah) sec = (hh > 0) ? SEC_NESW : SEC_NWSE;
    else sec = SEC_VERT;
    return {sec, mag[10:0]};
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, int value);
    if (idx == REG_WIDTH) reg_width = value & 32'h7FF;
    else reg_height = value & 32'h1FFF;
    in_count = 0;
    out_count = 0;
  endfunction

  // Advance the pipeline by one transaction; return 1 with the NMS result if one leaves
  function automatic bit nms_predict(input in_item_t it, output out_item_t res);
    int unsigned w, h, total, lag, s, x, q, qx, qy, p, px, py, m, n1, n2;
    logic [1:0] sec;
    logic [12:0] g, c;
    bit has_pix;
    res = '0;
    w = used_width();
    h = used_height();
    total = w * h;
    lag = 2 * w + 2;
    if (it.action == ACT_PIXEL && in_count < total) begin
      s = in_count;
      in_count++;
      has_pix = 1;
    end else if (in_count >= total && out_count < total) begin
      s = out_count + lag;
      has_pix = 0;
    end else begin
      return 0;
    end
    if (has_pix) begin
      x = s % w;
      for (int r = 0; r < 3; r++) begin
        pix_win[r][0] = pix_win[r][1];
        pix_win[r][1] = pix_win[r][2];
      end
      pix_win[0][2] = pix_rows[LINE + x];
      pix_win[1][2] = pix_rows[x];
      pix_win[2][2] = it.pixel;
      pix_rows[LINE + x] = pix_rows[x];
      pix_rows[x] = it.pixel;
    end
    if (s >= w + 1 && s - w - 1 < total) begin
      q = s - w - 1;
      qx = q % w;
      qy = q / w;
      g = '0;
      if (has_pix && is_interior(qx, qy, w, h)) g = center_gradient();
      for (int r = 0; r < 3; r++) begin
        grad_win[r][0] = grad_win[r][1];
        grad_win[r][1] = grad_win[r][2];
      end
      grad_win[0][2] = grad_rows[LINE + qx];
      grad_win[1][2] = grad_rows[qx];
      grad_win[2][2] = g;
      grad_rows[LINE + qx] = grad_rows[qx];
      grad_rows[qx] = g;
    end
    if (s < lag) return 0;
    p = s - lag;
    px = p % w;
    py = p / w;
    if (is_interior(px, py, w, h)) begin
      c = grad_win[1][1];
      m = c[10:0];
      sec = c[12:11];
      case (sec)
        SEC_HORZ: begin
          n1 = grad_win[1][0][10:0];
          n2 = grad_win[1][2][10:0];
        end
        SEC_NESW: begin
          n1 = grad_win[0][2][10:0];
          n2 = grad_win[2][0][10:0];
        end
        SEC_VERT: begin
          n1 = grad_win[0][1][10:0];
          n2 = grad_win[2][1][10:0];
        end
        default: begin
          n1 = grad_win[0][0][10:0];
          n2 = grad_win[2][2][10:0];
        end
      endcase
      res.direction = sec;
      if (m > n1 && m > n2) begin
        res.magnitude = 11'(m);
        res.is_peak = 1'b1;
      end
    end
    res.col = 10'(px);
    res.row = 12'(py);
    out_count = p + 1;
    if (out_count >= total) begin
      res.frame_end = 1'b1;
      in_count = 0;
      out_count = 0;
    end
    return 1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result at col", out_data.col, -1);
      end else begin
        if (out_data.col != pending_results[0].col)
          report_mismatch("col", out_data.col, pending_results[0].col);
        if (out_data.row != pending_results[0].row)
          report_mismatch("row", out_data.row, pending_results[0].row);
        if (out_data.magnitude != pending_results[0].magnitude)
          report_mismatch("magnitude", out_data.magnitude, pending_results[0].magnitude);
        if (out_data.direction != pending_results[0].direction)
          report_mismatch("direction", out_data.direction, pending_results[0].direction);
        if (out_data.is_peak != pending_results[0].is_peak)
          report_mismatch("is_peak", out_data.is_peak, pending_results[0].is_peak);
        if (out_data.frame_end != pending_results[0].frame_end)
          report_mismatch("frame_end", out_data.frame_end, pending_results[0].frame_end);
        void'(pending_results.pop_front());
      end
    end
  end

  // Stall the result side in bursts, with calm stretches
  int stall_left = 0;
  int stall_roll;
  always @(posedge clk) begin
    stall_roll = $urandom_range(0, 999);
    if (stall_roll < 2) steady_recv = !steady_recv;
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!steady_recv && stall_roll % 100 < 20) begin
      stall_left = (stall_roll % 100 < 18) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_send || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Drive one transaction; hold valid high into the next unless a gap follows
  task automatic send_item(in_item_t it, row_kind_t kind, out_item_t want);
    int gap;
    out_item_t res;
    bit has;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    has = nms_predict(it, res);
    if (kind == ROW_QUIET) begin
      if (has) report_mismatch("quiet row predicted result at col", res.col, -1);
    end else if (kind == ROW_TYPED) begin
      pending_results.push_back(want);
    end else if (has) begin
      pending_results.push_back(res);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, value);
  endtask

  // Frame content shapes
  int shape, edge_at;
  logic [7:0] lo_val, hi_val;

  function automatic logic [7:0] shaped_pixel(int x, int y);
    case (shape)
      0: return 8'($urandom);
      1: return (x >= edge_at) ? hi_val : lo_val;
      2: return (y >= edge_at) ? hi_val : lo_val;
      3: return (x + y >= edge_at) ? hi_val : lo_val;
      4: return (x - y >= edge_at - 4) ? hi_val : lo_val;
      default: return 8'((x >= edge_at ? hi_val : lo_val) + $urandom_range(0, 7));
    endcase
  endfunction

  function automatic in_item_t make_item(logic act, logic [7:0] px);
    in_item_t it;
    it.action = act;
    it.pixel = px;
    return it;
  endfunction

  // Send one frame; cut it short at abort_at if that lies inside the frame
  task automatic run_frame(int w, int h, int abort_at, bit pause_midway);
    int total;
    total = w * h;
    shape = $urandom_range(0, 5);
    edge_at = $urandom_range(0, w + h);
    lo_val = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
    hi_val = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
    for (int i = 0; i < total; i++) begin
      if (i == abort_at) return;
      if (pause_midway && i == total / 2) wait_drained();
      if ($urandom_range(0, 99) < 4)
        send_item(make_item(ACT_FLUSH, 8'($urandom)), ROW_MODEL, '0);
      send_item(make_item(ACT_PIXEL, shaped_pixel(i % w, i / w)), ROW_MODEL, '0);
    end
    for (int i = 0; i < 2 * w + 2; i++) begin
      if ($urandom_range(0, 4) == 0)
        send_item(make_item(ACT_PIXEL, 8'($urandom)), ROW_MODEL, '0);
      else
        send_item(make_item(ACT_FLUSH, 8'($urandom)), ROW_MODEL, '0);
    end
  endtask

  stim_row_t opening[] = '{
    '{ROW_QUIET, '{ACT_FLUSH, 8'h00}, 0, '0},
    '{ROW_QUIET, '{ACT_PIXEL, 8'hFF}, 0, '0},
    '{ROW_QUIET, '{ACT_PIXEL, 8'h00}, 0, '0},
    '{ROW_SET_W, '{ACT_FLUSH, 8'h00}, 0, '0},
    '{ROW_SET_H, '{ACT_FLUSH, 8'h00}, 2, '0},
    '{ROW_MODEL, '{ACT_PIXEL, 8'h00}, 0, '0},
    '{ROW_MODEL, '{ACT_PIXEL, 8'h00}, 0, '0},
    '{ROW_MODEL, '{ACT_PIXEL, 8'hFF}, 0, '0},
    '{ROW_QUIET, '{ACT_FLUSH, 8'hFF}, 0, '0},
    '{ROW_MODEL, '{ACT_PIXEL, 8'h00}, 0, '0},
    '{ROW_MODEL, '{ACT_PIXEL, 8'hFF}, 0, '0},
    '{ROW_MODEL, '{ACT_PIXEL, 8'hFF}, 0, '0},
    '{ROW_MODEL, '{ACT_PIXEL, 8'h00}, 0, '0},
    '{ROW_MODEL, '{ACT_PIXEL, 8'hFF}, 0, '0},
    '{ROW_MODEL, '{ACT_PIXEL, 8'hFF}, 0, '0},
    '{ROW_MODEL, '{ACT_FLUSH, 8'h00}, 0, '0},
    '{ROW_MODEL, '{ACT_FLUSH, 8'h00}, 0, '0},
    '{ROW_MODEL, '{ACT_PIXEL, 8'hAA}, 0, '0},
    '{ROW_MODEL, '{ACT_FLUSH, 8'h00}, 0, '0},
    '{ROW_MODEL, '{ACT_FLUSH, 8'h00}, 0, '0},
    '{ROW_MODEL, '{ACT_FLUSH, 8'h00}, 0, '0},
    '{ROW_MODEL, '{ACT_FLUSH, 8'h00}, 0, '0},
    '{ROW_TYPED, '{ACT_FLUSH, 8'h00}, 0,
      '{10'd2, 12'd2, 11'd0, SEC_HORZ, 1'b0, 1'b1}},
    '{ROW_SET_W, '{ACT_FLUSH, 8'h00}, 2047, '0},
    '{ROW_SET_H, '{ACT_FLUSH, 8'h00}, 8191, '0}
  };

  initial begin
    int w, h, frame_no, abort_at;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (opening[i]) begin
      case (opening[i].kind)
        ROW_SET_W: write_reg(REG_WIDTH, opening[i].value);
        ROW_SET_H: write_reg(REG_HEIGHT, opening[i].value);
        default: send_item(opening[i].item, opening[i].kind, opening[i].want);
      endcase
    end

    // Random frames, mostly small, two at the size extremes
    frame_no = 0;
    w = 4;
    h = 3;
    while (items_sent < 1650) begin
      steady_send = ($urandom_range(0, 5) == 0);
      abort_at = -1;
      if (frame_no == 6) begin
        w = 3;
        h = 3;
        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, 0);
      end else if (frame_no == 14) begin
        w = 1024;
        h = 4096;
        write_reg(REG_WIDTH, 2047);
        write_reg(REG_HEIGHT, 8191);
      end else if (frame_no == 0 || $urandom_range(0, 3) != 0) begin
        w = $urandom_range(3, 12);
        h = $urandom_range(3, 7);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
      end else if (frame_no == 6 + 1 || frame_no == 14 + 1) begin
        w = 5;
        h = 4;
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
      end
      if (w * h < 200 && $urandom_range(0, 9) == 0) abort_at = $urandom_range(1, w * h - 1);
      // Only the start of the largest frame is sent
      if (frame_no == 14) abort_at = $urandom_range(1, 200);
      run_frame(w, h, abort_at, frame_no == 3);
      // A cut-short frame must be restarted by a register write
      if (abort_at >= 0) write_reg(REG_HEIGHT, h);
      frame_no++;
    end

    wait_drained();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/sgnms_pkg.sv
hw/rtl/sgnms_isqrt.sv
hw/rtl/sobel_gradient_nonmax_suppress_top.sv
tb/sv/sobel_gradient_nonmax_suppress_top_tb.sv
